[rtl/tsgd_pkg.sv]
// ----------------------------------------------------------------------------
// tsgd_pkg
// Shared types and constants of the touch swipe gesture detector.
// ----------------------------------------------------------------------------
package tsgd_pkg;

   localparam int COORD_BITS = 16;
   localparam int OPC_W      = 3;
   localparam int VAL_W      = 16;
   localparam int REG_W      = 16;
   localparam int IDX_W      = 3;
   localparam int CMP_W      = REG_W + 1;

   // event kinds
   localparam logic [OPC_W-1:0] OP_POS_X = 3'd0;
   localparam logic [OPC_W-1:0] OP_POS_Y = 3'd1;
   localparam logic [OPC_W-1:0] OP_SLOT  = 3'd2;
   localparam logic [OPC_W-1:0] OP_TRACK = 3'd3;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_SLEEP_EN = 3'd0;
   localparam logic [IDX_W-1:0] CSR_WAKE_EN  = 3'd1;
   localparam logic [IDX_W-1:0] CSR_SCREEN   = 3'd2;
   localparam logic [IDX_W-1:0] CSR_Y_LIMIT  = 3'd3;
   localparam logic [IDX_W-1:0] CSR_EDGE_L   = 3'd4;
   localparam logic [IDX_W-1:0] CSR_EDGE_R   = 3'd5;
   localparam logic [IDX_W-1:0] CSR_GATE_RL  = 3'd6;
   localparam logic [IDX_W-1:0] CSR_GATE_LR  = 3'd7;

   localparam logic [REG_W-1:0] Y_LIMIT_RST = 16'd2400;
   localparam logic [REG_W-1:0] EDGE_L_RST  = 16'd250;
   localparam logic [REG_W-1:0] EDGE_R_RST  = 16'd1190;
   localparam logic [REG_W-1:0] GATE_RL_RST = 16'd700;
   localparam logic [REG_W-1:0] GATE_LR_RST = 16'd1040;

   // fixed inner boundaries
   localparam logic signed [CMP_W-1:0] INNER_RL = 17'sd400;
   localparam logic signed [CMP_W-1:0] INNER_LR = 17'sd380;

   localparam logic [1:0] BARRIER_ONE = 2'd1;
   localparam logic [1:0] BARRIER_TWO = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [1:0]       sleep_enable;
      logic             wake_enable;
      logic             screen_on;
      logic [REG_W-1:0] y_limit;
      logic [REG_W-1:0] edge_left;
      logic [REG_W-1:0] edge_right;
      logic [REG_W-1:0] gate_right_to_left;
      logic [REG_W-1:0] gate_left_to_right;
   } cfg_type;

   typedef struct packed {
      logic [1:0] rl_barriers;
      logic [1:0] lr_barriers;
      logic       trigger_armed;
   } progress_type;

   typedef struct packed {
      progress_type nxt;
      logic         pulse;
      logic         hold;
   } check_type;

   typedef struct packed {
      logic       power_toggle;
      logic       wake_hold;
      logic       hold_release;
      logic [1:0] rl_progress;
      logic [1:0] lr_progress;
   } rsp_type;

endpackage

[rtl/tsgd_if.sv]
// ----------------------------------------------------------------------------
// tsgd_req_if / tsgd_rsp_if
// Valid/ready channels for touch events and detector results.
// ----------------------------------------------------------------------------
interface tsgd_req_if;
   import tsgd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OPC_W-1:0]        opcode;
   logic signed [VAL_W-1:0] event_value;

   modport source (output valid, output opcode, output event_value, input ready);
   modport sink   (input valid, input opcode, input event_value, output ready);
endinterface

interface tsgd_rsp_if;
   logic       valid;
   logic       ready;
   logic       power_toggle;
   logic       wake_hold;
   logic       hold_release;
   logic [1:0] rl_progress;
   logic [1:0] lr_progress;

   modport source (output valid, output power_toggle, output wake_hold,
                   output hold_release, output rl_progress, output lr_progress,
                   input ready);
   modport sink   (input valid, input power_toggle, input wake_hold,
                   input hold_release, input rl_progress, input lr_progress,
                   output ready);
endinterface

[rtl/tsgd_csr.sv]
// ----------------------------------------------------------------------------
// tsgd_csr
// Configuration registers, written through a plain index/data port.
// ----------------------------------------------------------------------------
module tsgd_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [tsgd_pkg::IDX_W-1:0] csr_index,
   input  logic [tsgd_pkg::REG_W-1:0] csr_wdata,
   output tsgd_pkg::cfg_type       cfg
);
   import tsgd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SLEEP_EN: cfg_in.sleep_enable       = csr_wdata[1:0];
            CSR_WAKE_EN:  cfg_in.wake_enable        = csr_wdata[0];
            CSR_SCREEN:   cfg_in.screen_on          = csr_wdata[0];
            CSR_Y_LIMIT:  cfg_in.y_limit            = csr_wdata;
            CSR_EDGE_L:   cfg_in.edge_left          = csr_wdata;
            CSR_EDGE_R:   cfg_in.edge_right         = csr_wdata;
            CSR_GATE_RL:  cfg_in.gate_right_to_left = csr_wdata;
            CSR_GATE_LR:  cfg_in.gate_left_to_right = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sleep_enable       <= 2'd0;
         cfg_ff.wake_enable        <= 1'b0;
         cfg_ff.screen_on          <= 1'b0;
         cfg_ff.y_limit            <= Y_LIMIT_RST;
         cfg_ff.edge_left          <= EDGE_L_RST;
         cfg_ff.edge_right         <= EDGE_R_RST;
         cfg_ff.gate_right_to_left <= GATE_RL_RST;
         cfg_ff.gate_left_to_right <= GATE_LR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/tsgd_check.sv]
// ----------------------------------------------------------------------------
// tsgd_check
// Window checks of one latched point against both swipe barrier chains.
// ----------------------------------------------------------------------------
module tsgd_check (
   input  tsgd_pkg::cfg_type      cfg,
   input  tsgd_pkg::coord_type    x,
   input  tsgd_pkg::coord_type    y,
   input  tsgd_pkg::progress_type cur,
   output tsgd_pkg::check_type    res
);
   import tsgd_pkg::*;

   logic signed [CMP_W-1:0] xc, yc, b0, b2, b4, b5, yl;
   logic low, rl_s1, rl_s2, lr_s1, lr_s2, fire_rl, fire_lr;

   assign xc = CMP_W'(x);
   assign yc = CMP_W'(y);
   assign b0 = signed'({1'b0, cfg.edge_left});
   assign b5 = signed'({1'b0, cfg.edge_right});
   assign b2 = signed'({1'b0, cfg.gate_right_to_left});
   assign b4 = signed'({1'b0, cfg.gate_left_to_right});
   assign yl = signed'({1'b0, cfg.y_limit});
   assign low = yc > yl;

   assign rl_s1 = (cur.rl_barriers != 2'd0) || (xc < b5 && xc > b2 && low);
   assign rl_s2 = rl_s1 && ((cur.rl_barriers[1]) || (xc < b2 && xc > INNER_RL && low));
   assign fire_rl = rl_s2 && xc < INNER_RL && low && xc < b0 && cur.trigger_armed;

   assign lr_s1 = (cur.lr_barriers != 2'd0) || (xc > b0 && xc < INNER_LR && low);
   assign lr_s2 = lr_s1 && ((cur.lr_barriers[1]) || (xc > INNER_LR && xc < b4 && low));
   assign fire_lr = lr_s2 && xc > b4 && low && xc > b5 && cur.trigger_armed && !fire_rl;

   always_comb begin
      res.nxt = cur;
      if (rl_s1 && cur.rl_barriers == 2'd0) res.nxt.rl_barriers = BARRIER_ONE;
      if (rl_s2) res.nxt.rl_barriers = BARRIER_TWO;
      if (lr_s1 && cur.lr_barriers == 2'd0) res.nxt.lr_barriers = BARRIER_ONE;
      if (lr_s2) res.nxt.lr_barriers = BARRIER_TWO;
      if (fire_rl || fire_lr) res.nxt.trigger_armed = 1'b0;
      res.pulse = fire_rl || fire_lr;
      res.hold  = rl_s1 || lr_s1;
   end

endmodule

[rtl/touch_swipe_gesture_detector_unit.sv]
// ----------------------------------------------------------------------------
// touch_swipe_gesture_detector_unit
// Bottom-band horizontal swipe detector over a stream of multitouch events.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one multitouch event per beat (opcode, event_value).
//   rsp_ch returns exactly one result beat per event: power_toggle,
//   wake_hold, hold_release and both progress counts after the event.
//   csr_* writes a configuration register at any edge with csr_we high;
//   write only while no event is in flight.
// Timing:
//   An accepted event lands in an input register; once the result register
//   is free or being drained, an edge updates the gesture state and loads
//   the result register, and response valid rises with it. One event per
//   cycle is sustained while rsp_ch is ready; the state update is a single
//   compare-and-flag pass.
// Reset:
//   Synchronous, active high. Configuration registers return to their defaults, the
//   trigger is armed, progress and latched coordinates are cleared.
// Stalls:
//   While rsp_ch is stalled the result register holds; the input register
//   keeps one further event, after which req_ch.ready drops.
// ----------------------------------------------------------------------------
module touch_swipe_gesture_detector_unit (
   input  logic                          clock,
   input  logic                          reset,
   tsgd_req_if.sink                      req_ch,
   tsgd_rsp_if.source                    rsp_ch,
   input  logic                          csr_we,
   input  logic [tsgd_pkg::IDX_W-1:0]    csr_index,
   input  logic [tsgd_pkg::REG_W-1:0]    csr_wdata
);
   import tsgd_pkg::*;

   cfg_type      cfg;
   check_type    chk;

   logic                    in_valid_ff, in_valid_in;
   logic [OPC_W-1:0]        in_op_ff;
   logic signed [VAL_W-1:0] in_val_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   coord_type    x_ff, x_in, y_ff, y_in;
   logic         x_seen_ff, x_seen_in, y_seen_ff, y_seen_in;
   progress_type prog_ff, prog_in;

   logic advance, take, any_en, sel_en, release_ev, both_seen;

   tsgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tsgd_check u_check (
      .cfg (cfg),
      .x   (x_in),
      .y   (y_in),
      .cur (prog_ff),
      .res (chk)
   );

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign take         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   assign any_en     = (cfg.sleep_enable != 2'd0) || cfg.wake_enable;
   assign sel_en     = cfg.screen_on ? (cfg.sleep_enable != 2'd0) : cfg.wake_enable;
   assign release_ev = (in_op_ff == OP_SLOT && in_val_ff > 16'sd0) ||
                       (in_op_ff == OP_TRACK && in_val_ff == -16'sd1);

   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      x_seen_in = x_seen_ff;
      y_seen_in = y_seen_ff;
      prog_in   = prog_ff;
      rsp_in    = rsp_ff;
      both_seen = 1'b0;
      if (in_op_ff == OP_POS_X) x_in = in_val_ff[COORD_BITS-1:0];
      if (in_op_ff == OP_POS_Y) y_in = in_val_ff[COORD_BITS-1:0];
      if (take) begin
         rsp_in.power_toggle = 1'b0;
         rsp_in.wake_hold    = 1'b0;
         rsp_in.hold_release = 1'b0;
         if (!any_en) begin
            x_in = x_ff;
            y_in = y_ff;
         end else if (release_ev) begin
            x_in                  = x_ff;
            y_in                  = y_ff;
            prog_in.rl_barriers   = 2'd0;
            prog_in.lr_barriers   = 2'd0;
            prog_in.trigger_armed = 1'b1;
            rsp_in.hold_release   = 1'b1;
         end else begin
            x_seen_in = x_seen_ff || (in_op_ff == OP_POS_X);
            y_seen_in = y_seen_ff || (in_op_ff == OP_POS_Y);
            both_seen = x_seen_in && y_seen_in;
            if (both_seen) begin
               x_seen_in = 1'b0;
               y_seen_in = 1'b0;
               if (sel_en) begin
                  prog_in             = chk.nxt;
                  rsp_in.power_toggle = chk.pulse;
                  rsp_in.wake_hold    = chk.hold;
               end
            end
         end
         rsp_in.rl_progress = prog_in.rl_barriers;
         rsp_in.lr_progress = prog_in.lr_barriers;
      end else begin
         x_in = x_ff;
         y_in = y_ff;
      end
   end

   assign in_valid_in  = req_ch.ready ? req_ch.valid : in_valid_ff;
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         x_ff          <= '0;
         y_ff          <= '0;
         x_seen_ff     <= 1'b0;
         y_seen_ff     <= 1'b0;
         prog_ff.rl_barriers   <= 2'd0;
         prog_ff.lr_barriers   <= 2'd0;
         prog_ff.trigger_armed <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         x_seen_ff    <= x_seen_in;
         y_seen_ff    <= y_seen_in;
         prog_ff      <= prog_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_op_ff  <= req_ch.opcode;
         in_val_ff <= req_ch.event_value;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.power_toggle = rsp_ff.power_toggle;
   assign rsp_ch.wake_hold    = rsp_ff.wake_hold;
   assign rsp_ch.hold_release = rsp_ff.hold_release;
   assign rsp_ch.rl_progress  = rsp_ff.rl_progress;
   assign rsp_ch.lr_progress  = rsp_ff.lr_progress;

   // a completed swipe needs a full barrier chain
   a_pulse_progress: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.power_toggle |->
         rsp_ff.rl_progress == BARRIER_TWO || rsp_ff.lr_progress == BARRIER_TWO)
      else $error("power_toggle without full barrier chain");

   // a release clears progress and carries no gesture flags
   a_release_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.hold_release |->
         rsp_ff.rl_progress == 2'd0 && rsp_ff.lr_progress == 2'd0 &&
         !rsp_ff.power_toggle && !rsp_ff.wake_hold)
      else $error("release beat with progress or flags");

   // a pulse disarms the trigger
   a_disarm: assert property (@(posedge clock) disable iff (reset)
      take && rsp_in.power_toggle |=> !prog_ff.trigger_armed)
      else $error("trigger still armed after pulse");

   // progress never exceeds two barriers
   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      prog_ff.rl_barriers != 2'd3 && prog_ff.lr_barriers != 2'd3)
      else $error("barrier count out of range");

   // a stalled result is not overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result changed");

endmodule
